### rtl/core/ultrasonic_range_averager_unit_defines.svh
// Assertion macros for the ultrasonic range averager unit.
`ifndef ULTRASONIC_RANGE_AVERAGER_UNIT_DEFINES_SVH
`define ULTRASONIC_RANGE_AVERAGER_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF

// Clocked check, masked while reset is high.
`define URAV_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("urav: assertion failed");

// Clocked check that also holds across reset.
`define URAV_ASSERT_NR(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("urav: assertion failed");

`else

`define URAV_ASSERT(lbl, clk, rst, prop)
`define URAV_ASSERT_NR(lbl, clk, prop)

`endif

`endif

### rtl/core/urav_pkg.sv
// Package: types, constants and segment table of the range averager unit.
`timescale 1ns / 1ps
`default_nettype none

package urav_pkg;

   localparam int HISTORY_DEPTH = 3;

   localparam int RANGE_W     = 14;
   localparam int ECHO_W      = 16;
   localparam int SCALE_W     = 16;
   localparam int PROD_W      = ECHO_W + SCALE_W;
   localparam int PERIOD_W    = 8;
   localparam int TENTH_W     = 7;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;
   localparam int SEG_W       = 8;
   localparam int DIGIT_W     = 4;
   localparam int DIGITS      = 4;

   localparam int Q_DEPTH = 4;
   localparam int Q_PTR_W = $clog2(Q_DEPTH);
   localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

   localparam logic [RANGE_W-1:0] RANGE_MAX = {RANGE_W{1'b1}};

   // mm = count * scale / RANGE_DIVISOR: drop the low four bits, then multiply by
   // the reciprocal of RANGE_DIVISOR / 16; exact for every product below SAT_LIMIT
   localparam int RANGE_DIVISOR     = 10000;
   localparam int SAT_LIMIT         = RANGE_DIVISOR * (2 ** RANGE_W);
   localparam int RANGE_PRE_SHIFT   = 4;
   localparam int RANGE_IN_W        = $clog2(SAT_LIMIT) - RANGE_PRE_SHIFT;
   localparam int RANGE_RECIP       = 27487791;
   localparam int RANGE_RECIP_W     = 25;
   localparam int RANGE_RECIP_SHIFT = 34;
   localparam int RANGE_PROD_W      = RANGE_IN_W + RANGE_RECIP_W;
   localparam int STEP_W            = $clog2(DIGITS);

   // mean by reciprocal: exact for every sum below 2**SUM_W
   localparam int SUM_W        = RANGE_W + $clog2(HISTORY_DEPTH);
   localparam int MEAN_SHIFT   = SUM_W + $clog2(HISTORY_DEPTH);
   localparam int MEAN_RECIP   = (2 ** MEAN_SHIFT + HISTORY_DEPTH - 1) / HISTORY_DEPTH;
   localparam int MEAN_PROD_W  = SUM_W + MEAN_SHIFT;

   // divide by ten by reciprocal, exact for the range width
   localparam int DEC_RECIP  = 52429;
   localparam int DEC_SHIFT  = 19;
   localparam int DEC_PROD_W = DEC_SHIFT + RANGE_W;

   localparam logic [SEG_W-1:0] DASH  = 8'h40;
   localparam logic [SEG_W-1:0] POINT = 8'h80;

   localparam logic [TENTH_W-1:0] TENTH_RESET = 7'd60;

   localparam logic KIND_RANGE = 1'b0;
   localparam logic KIND_TENTH = 1'b1;

   typedef enum logic {
      OP_ECHO = 1'b0,
      OP_TICK = 1'b1
   } op_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_SCALE_FACTOR   = 3'd0,
      CSR_NEAR_LIMIT     = 3'd1,
      CSR_FAR_LIMIT      = 3'd2,
      CSR_DISPLAY_LIMIT  = 3'd3,
      CSR_DISPLAY_PERIOD = 3'd4,
      CSR_TENTH_PERIOD   = 3'd5,
      CSR_COUNT_TOP      = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic              operation;
      logic [ECHO_W-1:0] echo_count;
      logic              timed_out;
   } req_item_type;

   typedef struct packed {
      logic               kind;
      logic [SEG_W-1:0]   digit_ones;
      logic [SEG_W-1:0]   digit_tens;
      logic [SEG_W-1:0]   digit_hundreds;
      logic [SEG_W-1:0]   digit_thousands;
      logic [RANGE_W-1:0] range_value;
      logic [TENTH_W-1:0] count_value;
   } rsp_item_type;

   typedef struct packed {
      op_type            op;
      logic [ECHO_W-1:0] echo_count;
      logic              timed_out;
   } q_entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

   typedef struct packed {
      logic [SCALE_W-1:0]  scale_factor;
      logic [RANGE_W-1:0]  near_limit;
      logic [RANGE_W-1:0]  far_limit;
      logic [RANGE_W-1:0]  display_limit;
      logic [PERIOD_W-1:0] display_period;
      logic [TENTH_W-1:0]  tenth_period;
      logic [TENTH_W-1:0]  count_top;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      scale_factor:   16'd1914,
      near_limit:     14'd120,
      far_limit:      14'd150,
      display_limit:  14'd4000,
      display_period: 8'd200,
      tenth_period:   7'd100,
      count_top:      7'd119
   };

   function automatic logic [SEG_W-1:0] seg7(input logic [DIGIT_W-1:0] d);
      logic [SEG_W-1:0] s;
      case (d)
         4'd0:    s = 8'h3F;
         4'd1:    s = 8'h06;
         4'd2:    s = 8'h5B;
         4'd3:    s = 8'h4F;
         4'd4:    s = 8'h66;
         4'd5:    s = 8'h6D;
         4'd6:    s = 8'h7D;
         4'd7:    s = 8'h07;
         4'd8:    s = 8'h7F;
         4'd9:    s = 8'h6F;
         default: s = 8'h00;
      endcase
      return s;
   endfunction

endpackage

`default_nettype wire

### rtl/core/urav_front.sv
// Front end: accepts request transfers, classifies them and feeds the queue.
`timescale 1ns / 1ps
`default_nettype none

module urav_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  urav_pkg::req_item_type req_item,
   output logic                   push_valid,
   output urav_pkg::q_entry_type  push_entry,
   input  urav_pkg::q_status_type q_status
);
   import urav_pkg::*;

   logic        stage_valid_ff, stage_valid_in;
   q_entry_type stage_entry_ff, stage_entry_in;
   logic        push_ok;

   assign push_ok   = !q_status.full;
   assign req_ready = !stage_valid_ff || push_ok;

   always_comb begin
      stage_valid_in = stage_valid_ff && !push_ok;
      stage_entry_in = stage_entry_ff;
      if (req_ready) begin
         stage_valid_in = req_valid;
         if (req_item.operation) begin
            // tick: drop the echo fields
            stage_entry_in.op         = OP_TICK;
            stage_entry_in.echo_count = '0;
            stage_entry_in.timed_out  = 1'b0;
         end else begin
            stage_entry_in.op         = OP_ECHO;
            stage_entry_in.echo_count = req_item.echo_count;
            stage_entry_in.timed_out  = req_item.timed_out;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
      end
      stage_entry_ff <= stage_entry_in;
   end

   assign push_valid = stage_valid_ff;
   assign push_entry = stage_entry_ff;

endmodule

`default_nettype wire

### rtl/core/urav_queue.sv
// Short queue between the front end and the back end.
`timescale 1ns / 1ps
`default_nettype none

module urav_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push_valid,
   input  urav_pkg::q_entry_type  push_entry,
   input  logic                   pop,
   output urav_pkg::q_entry_type  pop_entry,
   output urav_pkg::q_status_type q_status
);
   import urav_pkg::*;

   q_entry_type        entries_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [Q_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [Q_CNT_W-1:0] count_ff, count_in;
   logic               do_push, do_pop;

   assign q_status.full  = (count_ff == Q_CNT_W'(Q_DEPTH));
   assign q_status.empty = (count_ff == '0);

   assign do_push = push_valid && !q_status.full;
   assign do_pop  = pop && !q_status.empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_ff + Q_PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_ff + Q_PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + Q_CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - Q_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

   assign pop_entry = entries_ff[rd_ptr_ff];

endmodule

`default_nettype wire

### rtl/core/urav_back.sv
// Back end: range computation, history mean, tenth counter, digit encoding.
`timescale 1ns / 1ps
`default_nettype none

module urav_back (
   input  logic                   clock,
   input  logic                   reset,
   input  urav_pkg::cfg_type      cfg,
   input  urav_pkg::q_status_type q_status,
   input  urav_pkg::q_entry_type  pop_entry,
   output logic                   pop,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output urav_pkg::rsp_item_type rsp_item
);
   import urav_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PREP,
      ST_AVG,
      ST_MEAN,
      ST_MODE,
      ST_DIGIT,
      ST_EMIT
   } state_type;

   state_type           state_ff, state_in;

   // model state
   logic [ECHO_W-1:0]   last_echo_ff, last_echo_in;
   logic                flag_ff, flag_in;
   logic                pending_ff, pending_in;
   logic [PERIOD_W-1:0] disp_ticks_ff, disp_ticks_in;
   logic [TENTH_W-1:0]  tenth_ticks_ff, tenth_ticks_in;
   logic [TENTH_W-1:0]  tenth_ctr_ff, tenth_ctr_in;
   logic                count_up_ff, count_up_in;
   logic                counting_ff, counting_in;
   logic [RANGE_W-1:0]  avg_ff, avg_in;
   logic [RANGE_W-1:0]  hist_ff [HISTORY_DEPTH];
   logic [RANGE_W-1:0]  hist_in [HISTORY_DEPTH];

   // working registers
   logic [STEP_W-1:0]   step_ff, step_in;
   logic [PROD_W-1:0]   prod_ff, prod_in;
   logic                sat_ff, sat_in;
   logic [RANGE_W-1:0]  quo_ff, quo_in;
   logic [RANGE_W-1:0]  r_ff, r_in;
   logic [SUM_W-1:0]    sum_ff, sum_in;
   logic                allnz_ff, allnz_in;
   logic [RANGE_W-1:0]  num_ff, num_in;
   logic [DIGIT_W-1:0]  dig_ff [DIGITS];
   logic [DIGIT_W-1:0]  dig_in [DIGITS];
   logic                res_kind_ff, res_kind_in;
   logic                res_dash_ff, res_dash_in;
   logic [RANGE_W-1:0]  res_range_ff, res_range_in;
   logic [TENTH_W-1:0]  res_count_ff, res_count_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_item_type        rsp_item_ff, rsp_item_in;

   // datapath helpers
   logic [ECHO_W-1:0]       echo_eff;
   logic                    disp_last;
   logic [TENTH_W-1:0]      tick_next;
   logic                    tenth_hit;
   logic [TENTH_W-1:0]      step_v;
   logic [TENTH_W-1:0]      step_store;
   logic [RANGE_PROD_W-1:0] range_prod;
   logic [RANGE_W-1:0]      r_sel;
   logic [RANGE_W-1:0]      new_hist [HISTORY_DEPTH];
   logic [SUM_W-1:0]        sum_calc;
   logic                    allnz_calc;
   logic [MEAN_PROD_W-1:0]  mean_prod;
   logic [DEC_PROD_W-1:0]   dec_prod;
   logic [RANGE_W-1:0]      dec_q;
   logic [RANGE_W-1:0]      dec_rem;
   logic                    show_dash;

   assign echo_eff   = pop_entry.timed_out ? last_echo_ff : pop_entry.echo_count;
   assign disp_last  = (disp_ticks_ff == (cfg.display_period - PERIOD_W'(1)));
   assign tick_next  = tenth_ticks_ff + TENTH_W'(1);
   assign tenth_hit  = (tick_next == cfg.tenth_period);
   assign range_prod = RANGE_PROD_W'(prod_ff[RANGE_PRE_SHIFT +: RANGE_IN_W]) *
                       RANGE_PROD_W'(RANGE_RECIP);
   assign r_sel      = sat_ff ? RANGE_MAX : quo_ff;
   assign mean_prod  = MEAN_PROD_W'(sum_ff) * MEAN_PROD_W'(MEAN_RECIP);
   assign dec_prod   = DEC_PROD_W'(num_ff) * DEC_PROD_W'(DEC_RECIP);
   assign dec_q      = dec_prod[DEC_SHIFT +: RANGE_W];
   assign dec_rem    = num_ff - ((dec_q << 3) + (dec_q << 1));
   assign show_dash  = (avg_ff >= cfg.display_limit) || flag_ff;

   // tenth counter step, up or down
   always_comb begin
      if (count_up_ff) begin
         step_v     = (tenth_ctr_ff >= cfg.count_top) ? '0 : tenth_ctr_ff + TENTH_W'(1);
         step_store = (step_v == cfg.count_top) ? '0 : step_v;
      end else begin
         step_v     = (tenth_ctr_ff == '0 || tenth_ctr_ff > cfg.count_top) ?
                      cfg.count_top : tenth_ctr_ff - TENTH_W'(1);
         step_store = (step_v == '0) ? cfg.count_top : step_v;
      end
   end

   // history shift and sum of the shifted history
   always_comb begin
      new_hist[0] = r_sel;
      for (int i = 1; i < HISTORY_DEPTH; i++) begin
         new_hist[i] = hist_ff[i-1];
      end
      sum_calc   = '0;
      allnz_calc = 1'b1;
      for (int i = 0; i < HISTORY_DEPTH; i++) begin
         sum_calc   = sum_calc + SUM_W'(new_hist[i]);
         allnz_calc = allnz_calc && (new_hist[i] != '0);
      end
   end

   always_comb begin
      state_in       = state_ff;
      last_echo_in   = last_echo_ff;
      flag_in        = flag_ff;
      pending_in     = pending_ff;
      disp_ticks_in  = disp_ticks_ff;
      tenth_ticks_in = tenth_ticks_ff;
      tenth_ctr_in   = tenth_ctr_ff;
      count_up_in    = count_up_ff;
      counting_in    = counting_ff;
      avg_in         = avg_ff;
      hist_in        = hist_ff;
      step_in        = step_ff;
      prod_in        = prod_ff;
      sat_in         = sat_ff;
      quo_in         = quo_ff;
      r_in           = r_ff;
      sum_in         = sum_ff;
      allnz_in       = allnz_ff;
      num_in         = num_ff;
      dig_in         = dig_ff;
      res_kind_in    = res_kind_ff;
      res_dash_in    = res_dash_ff;
      res_range_in   = res_range_ff;
      res_count_in   = res_count_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_item_in    = rsp_item_ff;
      pop            = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (!q_status.empty) begin
               pop = 1'b1;
               if (pop_entry.op == OP_TICK) begin
                  if (disp_last) begin
                     disp_ticks_in = '0;
                     pending_in    = 1'b1;
                  end else begin
                     disp_ticks_in = disp_ticks_ff + PERIOD_W'(1);
                  end
                  if (counting_ff) begin
                     if (tenth_hit) begin
                        tenth_ticks_in = '0;
                        tenth_ctr_in   = step_store;
                        res_kind_in    = KIND_TENTH;
                        res_dash_in    = 1'b0;
                        res_range_in   = avg_ff;
                        res_count_in   = step_v;
                        num_in         = RANGE_W'(step_v);
                        step_in        = '0;
                        state_in       = ST_DIGIT;
                     end else begin
                        tenth_ticks_in = tick_next;
                     end
                  end
               end else begin
                  flag_in      = flag_ff || pop_entry.timed_out;
                  last_echo_in = echo_eff;
                  prod_in      = PROD_W'(echo_eff) * PROD_W'(cfg.scale_factor);
                  state_in     = ST_PREP;
               end
            end
         end
         ST_PREP: begin
            sat_in   = (prod_ff >= PROD_W'(SAT_LIMIT));
            quo_in   = range_prod[RANGE_RECIP_SHIFT +: RANGE_W];
            state_in = ST_AVG;
         end
         ST_AVG: begin
            hist_in  = new_hist;
            r_in     = r_sel;
            sum_in   = sum_calc;
            allnz_in = allnz_calc;
            state_in = ST_MEAN;
         end
         ST_MEAN: begin
            avg_in   = allnz_ff ? mean_prod[MEAN_SHIFT +: RANGE_W] : r_ff;
            state_in = ST_MODE;
         end
         ST_MODE: begin
            if (avg_ff < cfg.near_limit) begin
               count_up_in = 1'b0;
               counting_in = 1'b1;
            end else if (avg_ff > cfg.far_limit) begin
               count_up_in = 1'b1;
               counting_in = 1'b1;
            end else begin
               counting_in = 1'b0;
            end
            if (pending_ff) begin
               pending_in   = 1'b0;
               res_kind_in  = KIND_RANGE;
               res_dash_in  = show_dash;
               res_range_in = avg_ff;
               res_count_in = tenth_ctr_ff;
               num_in       = avg_ff;
               step_in      = '0;
               if (show_dash) begin
                  flag_in = 1'b0;
               end
               state_in = ST_DIGIT;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_DIGIT: begin
            // shift in one decimal digit per cycle, lowest first
            for (int i = 0; i < DIGITS - 1; i++) begin
               dig_in[i] = dig_ff[i+1];
            end
            dig_in[DIGITS-1] = dec_rem[DIGIT_W-1:0];
            num_in  = dec_q;
            step_in = step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(DIGITS - 1)) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in             = 1'b1;
               rsp_item_in.kind         = res_kind_ff;
               rsp_item_in.range_value  = res_range_ff;
               rsp_item_in.count_value  = res_count_ff;
               if (res_dash_ff) begin
                  rsp_item_in.digit_ones      = DASH;
                  rsp_item_in.digit_tens      = DASH;
                  rsp_item_in.digit_hundreds  = DASH;
                  rsp_item_in.digit_thousands = DASH;
               end else begin
                  rsp_item_in.digit_ones      = seg7(dig_ff[0]);
                  rsp_item_in.digit_tens      = seg7(dig_ff[1]) | POINT;
                  rsp_item_in.digit_hundreds  = seg7(dig_ff[2]);
                  rsp_item_in.digit_thousands = (res_kind_ff == KIND_TENTH) ?
                                                '0 : seg7(dig_ff[3]);
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         last_echo_ff   <= '0;
         flag_ff        <= 1'b0;
         pending_ff     <= 1'b0;
         disp_ticks_ff  <= '0;
         tenth_ticks_ff <= '0;
         tenth_ctr_ff   <= TENTH_RESET;
         count_up_ff    <= 1'b0;
         counting_ff    <= 1'b0;
         avg_ff         <= '0;
         step_ff        <= '0;
         rsp_valid_ff   <= 1'b0;
         for (int i = 0; i < HISTORY_DEPTH; i++) begin
            hist_ff[i] <= '0;
         end
      end else begin
         state_ff       <= state_in;
         last_echo_ff   <= last_echo_in;
         flag_ff        <= flag_in;
         pending_ff     <= pending_in;
         disp_ticks_ff  <= disp_ticks_in;
         tenth_ticks_ff <= tenth_ticks_in;
         tenth_ctr_ff   <= tenth_ctr_in;
         count_up_ff    <= count_up_in;
         counting_ff    <= counting_in;
         avg_ff         <= avg_in;
         step_ff        <= step_in;
         rsp_valid_ff   <= rsp_valid_in;
         hist_ff        <= hist_in;
      end
      prod_ff      <= prod_in;
      sat_ff       <= sat_in;
      quo_ff       <= quo_in;
      r_ff         <= r_in;
      sum_ff       <= sum_in;
      allnz_ff     <= allnz_in;
      num_ff       <= num_in;
      dig_ff       <= dig_in;
      res_kind_ff  <= res_kind_in;
      res_dash_ff  <= res_dash_in;
      res_range_ff <= res_range_in;
      res_count_ff <= res_count_in;
      rsp_item_ff  <= rsp_item_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

endmodule

`default_nettype wire

### rtl/core/ultrasonic_range_averager_unit.sv
// Top level of the ultrasonic range averager unit.
//
// Channel  Dir  Handshake            Payload
// req      in   req_valid/req_ready  req_item: operation, echo_count, timed_out
// rsp      out  rsp_valid/rsp_ready  rsp_item: kind, four digits, range, count
// csr      in   csr_we               csr_index, csr_wdata (no read-back)
//
// The front end takes one request transfer per cycle while its stage and the
// four-entry queue have room. The back end handles a tick in its idle step,
// with no result or with a counter update that goes on to digit encoding; an
// echo takes one step each for the scale multiply, the reciprocal divide, the
// history sum, the mean and the mode, and any update adds one step per digit
// plus one to load the output register.
// Reset is synchronous and immediate: there is no clearing pass.
// A stalled result transfer stops only the back end, in its last step.
`timescale 1ns / 1ps
`default_nettype none

`include "ultrasonic_range_averager_unit_defines.svh"

module ultrasonic_range_averager_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  urav_pkg::req_item_type              req_item,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output urav_pkg::rsp_item_type              rsp_item,
   input  logic                                csr_we,
   input  logic [urav_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [urav_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import urav_pkg::*;

   cfg_type      cfg_ff, cfg_in;
   logic         push_valid;
   q_entry_type  push_entry;
   q_entry_type  pop_entry;
   logic         pop;
   q_status_type q_status;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_SCALE_FACTOR:   cfg_in.scale_factor   = csr_wdata[SCALE_W-1:0];
            CSR_NEAR_LIMIT:     cfg_in.near_limit     = csr_wdata[RANGE_W-1:0];
            CSR_FAR_LIMIT:      cfg_in.far_limit      = csr_wdata[RANGE_W-1:0];
            CSR_DISPLAY_LIMIT:  cfg_in.display_limit  = csr_wdata[RANGE_W-1:0];
            CSR_DISPLAY_PERIOD: cfg_in.display_period = csr_wdata[PERIOD_W-1:0];
            CSR_TENTH_PERIOD:   cfg_in.tenth_period   = csr_wdata[TENTH_W-1:0];
            CSR_COUNT_TOP:      cfg_in.count_top      = csr_wdata[TENTH_W-1:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   urav_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_item   (req_item),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .q_status   (q_status)
   );

   urav_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .pop        (pop),
      .pop_entry  (pop_entry),
      .q_status   (q_status)
   );

   urav_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .q_status  (q_status),
      .pop_entry (pop_entry),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item)
   );

   // no result is offered in the cycle after reset
   `URAV_ASSERT_NR(a_quiet_after_reset, clock, reset |=> !rsp_valid)
   // the front end stalls only on a full queue
   `URAV_ASSERT(a_stall_on_full, clock, reset, !req_ready |-> q_status.full)
   // a counter update never shows a thousands digit
   `URAV_ASSERT(a_tenth_no_thousands, clock, reset,
      (rsp_valid && rsp_item.kind == KIND_TENTH) |-> (rsp_item.digit_thousands == '0))
   // every digit display carries the decimal point on the tens digit
   `URAV_ASSERT(a_point_with_digits, clock, reset,
      (rsp_valid && rsp_item.digit_ones != DASH) |-> ((rsp_item.digit_tens & POINT) != '0))

endmodule

`default_nettype wire
